// ----- hw/rtl/dsil_pkg.sv -----
// ----------------------------------------------------------------------------
// dsil_pkg
// Shared types and constants for the depth sorted insert list.
// ----------------------------------------------------------------------------
`default_nettype none

package dsil_pkg;

  localparam int ID_W               = 16;
  localparam int COORD_W            = 16;
  localparam int KEY_W              = 38;
  localparam int CFG_IDX_W          = 2;
  localparam int CFG_DATA_W         = 16;
  localparam int DEFAULT_LIST_DEPTH = 64;

  localparam logic [KEY_W-1:0] FAR_KEY = 38'd4000000000;

  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_Z = 2'd2;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_DRAIN  = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_STORED  = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_DRAINED = 2'd2,
    STAT_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_KEY   = 2'd1,
    S_CMP   = 2'd2,
    S_DRAIN = 2'd3
  } state_t;

  typedef enum logic [2:0] {
    CMD_HOLD   = 3'd0,
    CMD_CMP    = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_APPEND = 3'd3,
    CMD_DRAIN  = 3'd4
  } cell_cmd_t;

  typedef struct packed {
    logic             valid;
    logic             ge;
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  handle;
  } cell_link_t;

endpackage

`default_nettype wire

// ----- hw/rtl/depth_sorted_insert_list_unit.sv -----
// ----------------------------------------------------------------------------
// depth_sorted_insert_list_unit
// Back-to-front list of objects kept in a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; each result shows for
// one cycle with out_valid and cannot be held off. A sorted insert passes
// through the key pipeline (deltas, squares, sum), then every cell compares its
// key, then the whole chain shifts and writes before the next acceptance. An
// append, or an insert or append into a full list, ends after the key pipeline.
// A drain gives the head cell's entry, one entry a cycle, as the chain shifts
// forward; a drain of an empty list answers with an empty status, and an
// unused request code is taken without giving any result.
// ----------------------------------------------------------------------------
`default_nettype none

module depth_sorted_insert_list_unit #(
  parameter int LIST_DEPTH = dsil_pkg::DEFAULT_LIST_DEPTH
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic [1:0]                            in_req_type,
  input  wire logic [dsil_pkg::ID_W-1:0]             in_entity_id,
  input  wire logic                                  in_force_far,
  input  wire logic signed [dsil_pkg::COORD_W-1:0]   in_origin_x,
  input  wire logic signed [dsil_pkg::COORD_W-1:0]   in_origin_y,
  input  wire logic signed [dsil_pkg::COORD_W-1:0]   in_origin_z,
  input  wire logic signed [dsil_pkg::COORD_W-1:0]   in_box_min_x,
  input  wire logic signed [dsil_pkg::COORD_W-1:0]   in_box_min_y,
  input  wire logic signed [dsil_pkg::COORD_W-1:0]   in_box_min_z,
  input  wire logic signed [dsil_pkg::COORD_W-1:0]   in_box_max_x,
  input  wire logic signed [dsil_pkg::COORD_W-1:0]   in_box_max_y,
  input  wire logic signed [dsil_pkg::COORD_W-1:0]   in_box_max_z,
  input  wire logic                                  cfg_we,
  input  wire logic [dsil_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [dsil_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic                                       out_valid,
  output logic [dsil_pkg::ID_W-1:0]                  out_entity,
  output logic [dsil_pkg::KEY_W-1:0]                 out_key,
  output logic [1:0]                                 out_status,
  output logic                                       out_last
);
  import dsil_pkg::*;

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);

  state_t            state_r, state_nxt;
  req_t              req_r, req_nxt;
  logic [ID_W-1:0]   ent_r, ent_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  cell_cmd_t         cmd;
  logic              key_go;
  logic              key_done;
  logic [KEY_W-1:0]  key_val;

  logic signed [COORD_W-1:0] view_x_r, view_y_r, view_z_r;

  logic              out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]   out_entity_r, out_entity_nxt;
  logic [KEY_W-1:0]  out_key_r, out_key_nxt;
  status_t           out_status_r, out_status_nxt;
  logic              out_last_r, out_last_nxt;

  cell_link_t        link [LIST_DEPTH];
  logic [LIST_DEPTH:0] sfx;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_x_r <= '0;
      view_y_r <= '0;
      view_z_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VIEW_X: view_x_r <= cfg_data;
        CFG_VIEW_Y: view_y_r <= cfg_data;
        CFG_VIEW_Z: view_z_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign key_go = start && (state_r == S_IDLE) &&
                  ((in_req_type == REQ_INSERT) || (in_req_type == REQ_APPEND));

  dsil_key u_key (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (key_go),
    .far       (in_force_far && (in_req_type == REQ_INSERT)),
    .view_x    (view_x_r),
    .view_y    (view_y_r),
    .view_z    (view_z_r),
    .origin_x  (in_origin_x),
    .origin_y  (in_origin_y),
    .origin_z  (in_origin_z),
    .box_min_x (in_box_min_x),
    .box_min_y (in_box_min_y),
    .box_min_z (in_box_min_z),
    .box_max_x (in_box_max_x),
    .box_max_y (in_box_max_y),
    .box_max_z (in_box_max_z),
    .done      (key_done),
    .key       (key_val)
  );

  // cell chain, head at index 0
  assign sfx[LIST_DEPTH] = 1'b0;

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    cell_link_t prev_l, next_l;

    if (i == 0) begin : g_head
      assign prev_l = '{valid: 1'b1, ge: 1'b1, key: '0, handle: '0};
    end else begin : g_mid
      assign prev_l = link[i-1];
    end

    if (i == LIST_DEPTH - 1) begin : g_tail
      assign next_l = '{valid: 1'b0, ge: 1'b0, key: '0, handle: '0};
    end else begin : g_body
      assign next_l = link[i+1];
    end

    dsil_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .new_key    (key_val),
      .new_handle (ent_r),
      .prev_link  (prev_l),
      .next_link  (next_l),
      .sfx_in     (sfx[i+1]),
      .sfx_out    (sfx[i]),
      .link       (link[i])
    );
  end

  // control
  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    ent_nxt        = ent_r;
    count_nxt      = count_r;
    cmd            = CMD_HOLD;
    out_valid_nxt  = 1'b0;
    out_entity_nxt = out_entity_r;
    out_key_nxt    = out_key_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt = req_t'(in_req_type);
          ent_nxt = in_entity_id;
          case (req_t'(in_req_type))
            REQ_INSERT, REQ_APPEND: begin
              state_nxt = S_KEY;
            end
            REQ_DRAIN: begin
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_entity_nxt = '0;
                out_key_nxt    = '0;
                out_status_nxt = STAT_EMPTY;
                out_last_nxt   = 1'b1;
              end else begin
                state_nxt = S_DRAIN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_KEY: begin
        if (key_done) begin
          out_entity_nxt = ent_r;
          out_key_nxt    = key_val;
          if (count_r == CNT_W'(LIST_DEPTH)) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_FULL;
            out_last_nxt   = 1'b1;
            state_nxt      = S_IDLE;
          end else if (req_r == REQ_APPEND) begin
            cmd            = CMD_APPEND;
            count_nxt      = count_r + 1'b1;
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_STORED;
            out_last_nxt   = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            cmd       = CMD_CMP;
            state_nxt = S_CMP;
          end
        end
      end
      S_CMP: begin
        cmd            = CMD_INSERT;
        count_nxt      = count_r + 1'b1;
        out_valid_nxt  = 1'b1;
        out_status_nxt = STAT_STORED;
        out_last_nxt   = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_DRAIN: begin
        cmd            = CMD_DRAIN;
        count_nxt      = count_r - 1'b1;
        out_valid_nxt  = 1'b1;
        out_entity_nxt = link[0].handle;
        out_key_nxt    = link[0].key;
        out_status_nxt = STAT_DRAINED;
        out_last_nxt   = (count_r == CNT_W'(1));
        if (count_r == CNT_W'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    ent_r        <= ent_nxt;
    out_entity_r <= out_entity_nxt;
    out_key_r    <= out_key_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_entity = out_entity_r;
  assign out_key    = out_key_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule

`default_nettype wire

// ----- hw/rtl/dsil_key.sv -----
// ----------------------------------------------------------------------------
// dsil_key
// Three stage distance key pipeline: axis deltas, squares, sum and far select.
// ----------------------------------------------------------------------------
`default_nettype none

module dsil_key (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                go,
  input  wire logic                                far,
  input  wire logic signed [dsil_pkg::COORD_W-1:0] view_x,
  input  wire logic signed [dsil_pkg::COORD_W-1:0] view_y,
  input  wire logic signed [dsil_pkg::COORD_W-1:0] view_z,
  input  wire logic signed [dsil_pkg::COORD_W-1:0] origin_x,
  input  wire logic signed [dsil_pkg::COORD_W-1:0] origin_y,
  input  wire logic signed [dsil_pkg::COORD_W-1:0] origin_z,
  input  wire logic signed [dsil_pkg::COORD_W-1:0] box_min_x,
  input  wire logic signed [dsil_pkg::COORD_W-1:0] box_min_y,
  input  wire logic signed [dsil_pkg::COORD_W-1:0] box_min_z,
  input  wire logic signed [dsil_pkg::COORD_W-1:0] box_max_x,
  input  wire logic signed [dsil_pkg::COORD_W-1:0] box_max_y,
  input  wire logic signed [dsil_pkg::COORD_W-1:0] box_max_z,
  output logic                                     done,
  output logic [dsil_pkg::KEY_W-1:0]               key
);
  import dsil_pkg::*;

  localparam int D_W  = COORD_W + 3;
  localparam int A_W  = COORD_W + 2;
  localparam int SQ_W = 2 * A_W;

  logic signed [D_W-1:0] dx, dy, dz;
  logic [A_W-1:0]  ax_nxt, ay_nxt, az_nxt;
  logic [A_W-1:0]  ax_r, ay_r, az_r;
  logic [SQ_W-1:0] sx_r, sy_r, sz_r;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic v1_r, v2_r, done_r;
  logic far1_r, far2_r;

  always_comb begin
    dx = (D_W'(view_x) <<< 1) - (D_W'(origin_x) <<< 1) - D_W'(box_min_x) - D_W'(box_max_x);
    dy = (D_W'(view_y) <<< 1) - (D_W'(origin_y) <<< 1) - D_W'(box_min_y) - D_W'(box_max_y);
    dz = (D_W'(view_z) <<< 1) - (D_W'(origin_z) <<< 1) - D_W'(box_min_z) - D_W'(box_max_z);
    ax_nxt = dx[D_W-1] ? A_W'(-dx) : A_W'(dx);
    ay_nxt = dy[D_W-1] ? A_W'(-dy) : A_W'(dy);
    az_nxt = dz[D_W-1] ? A_W'(-dz) : A_W'(dz);
    key_nxt = far2_r ? FAR_KEY : KEY_W'(sx_r) + KEY_W'(sy_r) + KEY_W'(sz_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= go;
      v2_r   <= v1_r;
      done_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      ax_r   <= ax_nxt;
      ay_r   <= ay_nxt;
      az_r   <= az_nxt;
      far1_r <= far;
    end
    if (v1_r) begin
      sx_r   <= SQ_W'(ax_r) * SQ_W'(ax_r);
      sy_r   <= SQ_W'(ay_r) * SQ_W'(ay_r);
      sz_r   <= SQ_W'(az_r) * SQ_W'(az_r);
      far2_r <= far1_r;
    end
    if (v2_r) begin
      key_r <= key_nxt;
    end
  end

  assign done = done_r;
  assign key  = key_r;

endmodule

`default_nettype wire

// ----- hw/rtl/dsil_cell.sv -----
// ----------------------------------------------------------------------------
// dsil_cell
// One list slot: compares against a new key and shifts with its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module dsil_cell (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire dsil_pkg::cell_cmd_t         cmd,
  input  wire logic [dsil_pkg::KEY_W-1:0]  new_key,
  input  wire logic [dsil_pkg::ID_W-1:0]   new_handle,
  input  wire dsil_pkg::cell_link_t        prev_link,
  input  wire dsil_pkg::cell_link_t        next_link,
  input  wire logic                        sfx_in,
  output logic                             sfx_out,
  output dsil_pkg::cell_link_t             link
);
  import dsil_pkg::*;

  logic             valid_r, valid_nxt;
  logic             ge_r, ge_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [ID_W-1:0]  handle_r, handle_nxt;

  always_comb begin
    valid_nxt  = valid_r;
    ge_nxt     = ge_r;
    key_nxt    = key_r;
    handle_nxt = handle_r;
    case (cmd)
      CMD_CMP: begin
        ge_nxt = valid_r && (key_r >= new_key);
      end
      CMD_INSERT: begin
        ge_nxt = 1'b0;
        if (!sfx_in && !ge_r) begin
          if (prev_link.ge) begin
            valid_nxt  = 1'b1;
            key_nxt    = new_key;
            handle_nxt = new_handle;
          end else begin
            valid_nxt  = prev_link.valid;
            key_nxt    = prev_link.key;
            handle_nxt = prev_link.handle;
          end
        end
      end
      CMD_APPEND: begin
        if (!valid_r && prev_link.valid) begin
          valid_nxt  = 1'b1;
          key_nxt    = new_key;
          handle_nxt = new_handle;
        end
      end
      CMD_DRAIN: begin
        valid_nxt  = next_link.valid;
        key_nxt    = next_link.key;
        handle_nxt = next_link.handle;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      ge_r    <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      ge_r    <= ge_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    handle_r <= handle_nxt;
  end

  assign sfx_out     = sfx_in | ge_r;
  assign link.valid  = valid_r;
  assign link.ge     = ge_r;
  assign link.key    = key_r;
  assign link.handle = handle_r;

endmodule

`default_nettype wire

// ----- tb/tb_depth_sorted_insert_list_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_depth_sorted_insert_list_unit
// Self-checking bench for the back-to-front sorted insert list.
// ----------------------------------------------------------------------------
// A queue of requests, filled phase by phase, feeds a clocked driver with
// random gaps. Every accepted request runs through a behavioral copy of the
// list that works out the depth key, places the entry farthest first (ties go
// behind), appends, drops on a full list and drains in order. A monitor checks
// each strobed result against the oldest expected one. The view origin is
// rewritten between phases while the unit is idle, extremes included.
// ----------------------------------------------------------------------------

module tb_depth_sorted_insert_list_unit;
  import dsil_pkg::*;

  localparam int LIST_DEPTH  = DEFAULT_LIST_DEPTH;
  localparam int QUIET_LIMIT = 2000;
  localparam int RAND_PHASE  = 28;

  typedef struct packed {
    req_t               req;
    logic [ID_W-1:0]    id;
    logic               far;
    logic [COORD_W-1:0] org_x, org_y, org_z;
    logic [COORD_W-1:0] bmin_x, bmin_y, bmin_z;
    logic [COORD_W-1:0] bmax_x, bmax_y, bmax_z;
  } list_req_t;

  typedef struct packed {
    logic [ID_W-1:0]  entity;
    logic [KEY_W-1:0] key;
    status_t          status;
    logic             last;
  } list_out_t;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_VIEW_X;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic out_valid;
  logic [ID_W-1:0] out_entity;
  logic [KEY_W-1:0] out_key;
  logic [1:0] out_status;
  logic out_last;

  list_req_t cur = '0;

  // view origin and list contents as the unit should hold them
  logic signed [COORD_W-1:0] view_x = '0, view_y = '0, view_z = '0;
  logic [KEY_W-1:0] depth_keys[$];
  logic [ID_W-1:0]  depth_ids[$];

  list_req_t request_backlog[$];
  list_out_t due_results[$];

  int errors = 0;
  int gap = 0;
  int next_gap;
  bit steady = 1'b0;
  int quiet = 0;

  depth_sorted_insert_list_unit #(.LIST_DEPTH(LIST_DEPTH)) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_req_type (cur.req),
    .in_entity_id(cur.id),
    .in_force_far(cur.far),
    .in_origin_x (cur.org_x),
    .in_origin_y (cur.org_y),
    .in_origin_z (cur.org_z),
    .in_box_min_x(cur.bmin_x),
    .in_box_min_y(cur.bmin_y),
    .in_box_min_z(cur.bmin_z),
    .in_box_max_x(cur.bmax_x),
    .in_box_max_y(cur.bmax_y),
    .in_box_max_z(cur.bmax_z),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_entity  (out_entity),
    .out_key     (out_key),
    .out_status  (out_status),
    .out_last    (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint axis_delta(logic signed [COORD_W-1:0] view,
                                        logic [COORD_W-1:0] org,
                                        logic [COORD_W-1:0] bmin,
                                        logic [COORD_W-1:0] bmax);
    return 2 * longint'(view) - 2 * longint'($signed(org))
           - longint'($signed(bmin)) - longint'($signed(bmax));
  endfunction

  // four times the squared distance from the view to the box centre
  function automatic logic [KEY_W-1:0] depth_key(list_req_t r);
    longint dx, dy, dz;
    dx = axis_delta(view_x, r.org_x, r.bmin_x, r.bmax_x);
    dy = axis_delta(view_y, r.org_y, r.bmin_y, r.bmax_y);
    dz = axis_delta(view_z, r.org_z, r.bmin_z, r.bmax_z);
    return KEY_W'(dx * dx + dy * dy + dz * dz);
  endfunction

  function automatic void expect_result(logic [ID_W-1:0] entity, logic [KEY_W-1:0] key,
                                        status_t status, logic last);
    list_out_t e;
    e.entity = entity;
    e.key    = key;
    e.status = status;
    e.last   = last;
    due_results.push_back(e);
  endfunction

  function automatic void apply_request(list_req_t r);
    logic [KEY_W-1:0] key;
    int pos;
    case (r.req)
      REQ_DRAIN: begin
        if (depth_keys.size() == 0) begin
          expect_result('0, '0, STAT_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < depth_keys.size(); i++)
            expect_result(depth_ids[i], depth_keys[i], STAT_DRAINED,
                          i == depth_keys.size() - 1);
          depth_keys.delete();
          depth_ids.delete();
        end
      end
      REQ_NONE: ;
      default: begin
        key = (r.req == REQ_INSERT && r.far) ? FAR_KEY : depth_key(r);
        if (depth_keys.size() >= LIST_DEPTH) begin
          expect_result(r.id, key, STAT_FULL, 1'b1);
        end else begin
          pos = depth_keys.size();
          if (r.req == REQ_INSERT)
            while (pos > 0 && depth_keys[pos-1] < key) pos--;
          depth_keys.insert(pos, key);
          depth_ids.insert(pos, r.id);
          expect_result(r.id, key, STAT_STORED, 1'b1);
        end
      end
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap <= 0;
    end else if (start && !busy) begin
      apply_request(cur);
      if ($urandom_range(0, 11) == 0) steady = !steady;
      next_gap = steady ? 0 : $urandom_range(0, 4);
      if (next_gap == 0 && request_backlog.size() != 0) begin
        cur <= request_backlog.pop_front();
      end else begin
        start <= 1'b0;
        gap <= next_gap;
      end
    end else if (!start) begin
      if (gap != 0) begin
        gap <= gap - 1;
      end else if (request_backlog.size() != 0) begin
        cur <= request_backlog.pop_front();
        start <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    list_out_t e;
    if (rst_n && out_valid) begin
      if (due_results.size() == 0) begin
        $error("unexpected result: entity %0h key %0d status %0d", out_entity, out_key,
               out_status);
        errors++;
      end else begin
        e = due_results.pop_front();
        if (out_entity !== e.entity) begin
          $error("out_entity: expected %0h, got %0h", e.entity, out_entity);
          errors++;
        end
        if (out_key !== e.key) begin
          $error("out_key: expected %0d, got %0d", e.key, out_key);
          errors++;
        end
        if (out_status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_status);
          errors++;
        end
        if (out_last !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, out_last);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic wait_idle;
    do @(negedge clk);
    while (request_backlog.size() != 0 || start || due_results.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_view(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                          logic signed [COORD_W-1:0] z);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_VIEW_X;
    cfg_data <= x;
    view_x = x;
    @(posedge clk);
    cfg_index <= CFG_VIEW_Y;
    cfg_data <= y;
    view_y = y;
    @(posedge clk);
    cfg_index <= CFG_VIEW_Z;
    cfg_data <= z;
    view_z = z;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // same origin and box corners on all three axes
  task automatic queue_request(req_t req, logic [ID_W-1:0] id, logic far,
                               logic [COORD_W-1:0] org, logic [COORD_W-1:0] bmin,
                               logic [COORD_W-1:0] bmax);
    list_req_t r;
    r.req = req;
    r.id = id;
    r.far = far;
    r.org_x = org;
    r.org_y = org;
    r.org_z = org;
    r.bmin_x = bmin;
    r.bmin_y = bmin;
    r.bmin_z = bmin;
    r.bmax_x = bmax;
    r.bmax_y = bmax;
    r.bmax_z = bmax;
    request_backlog.push_back(r);
  endtask

  function automatic logic [COORD_W-1:0] rand_coord(int style);
    case (style)
      0, 1: return COORD_W'($urandom_range(0, 4)) - COORD_W'(2);
      2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic list_req_t rand_request(bit fill_only);
    list_req_t r;
    int pick, style;
    pick = fill_only ? $urandom_range(0, 79) : $urandom_range(0, 99);
    style = $urandom_range(0, 7);
    r.req = pick < 55 ? REQ_INSERT : pick < 80 ? REQ_APPEND :
            pick < 93 ? REQ_DRAIN : REQ_NONE;
    r.id = ID_W'($urandom);
    r.far = ($urandom_range(0, 3) == 0);
    r.org_x = rand_coord(style);
    r.org_y = rand_coord(style);
    r.org_z = rand_coord(style);
    r.bmin_x = rand_coord(style);
    r.bmin_y = rand_coord(style);
    r.bmin_z = rand_coord(style);
    r.bmax_x = rand_coord(style);
    r.bmax_y = rand_coord(style);
    r.bmax_z = rand_coord(style);
    return r;
  endfunction

  task automatic random_phase(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                              logic signed [COORD_W-1:0] z);
    wait_idle();
    set_view(x, y, z);
    for (int i = 0; i < RAND_PHASE; i++) request_backlog.push_back(rand_request(1'b0));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty drain, ties, far keys, coordinate extremes
    wait_idle();
    set_view(16'sd0, 16'sd0, 16'sd0);
    queue_request(REQ_DRAIN, 16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000);
    queue_request(REQ_NONE, 16'h1234, 1'b1, 16'h5555, 16'haaaa, 16'h5555);
    queue_request(REQ_INSERT, 16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000);
    queue_request(REQ_INSERT, 16'hffff, 1'b1, 16'h1357, 16'hfedc, 16'h0246);
    queue_request(REQ_INSERT, 16'h0001, 1'b1, 16'h8000, 16'h8000, 16'h8000);
    queue_request(REQ_INSERT, 16'h0002, 1'b0, 16'h8000, 16'h8000, 16'h8000);
    queue_request(REQ_INSERT, 16'h0003, 1'b0, 16'h7fff, 16'h7fff, 16'h7fff);
    queue_request(REQ_APPEND, 16'h0004, 1'b1, 16'h0000, 16'h0000, 16'h0000);
    queue_request(REQ_APPEND, 16'h0005, 1'b0, 16'h8000, 16'h7fff, 16'h8000);
    queue_request(REQ_INSERT, 16'h0006, 1'b0, 16'h0000, 16'h0000, 16'h0000);
    queue_request(REQ_DRAIN, 16'hffff, 1'b1, 16'hffff, 16'hffff, 16'hffff);
    queue_request(REQ_DRAIN, 16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000);

    // sender holds off until the list unit has answered everything
    wait_idle();
    set_view(-16'sd32768, -16'sd32768, -16'sd32768);
    queue_request(REQ_INSERT, 16'h8000, 1'b0, 16'h7fff, 16'h7fff, 16'h7fff);
    queue_request(REQ_INSERT, 16'h7fff, 1'b0, 16'h8000, 16'h8000, 16'h8000);
    queue_request(REQ_APPEND, 16'haaaa, 1'b0, 16'h7fff, 16'h8000, 16'h7fff);
    queue_request(REQ_NONE, 16'h5555, 1'b0, 16'h0000, 16'h0000, 16'h0000);
    queue_request(REQ_INSERT, 16'h5555, 1'b1, 16'h7fff, 16'h7fff, 16'h7fff);
    queue_request(REQ_DRAIN, 16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000);

    random_phase(16'sd1, -16'sd1, 16'sd0);
    random_phase(16'sd32767, 16'sd32767, 16'sd32767);
    random_phase(-16'sd32768, -16'sd32768, -16'sd32768);
    random_phase(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));

    // fill the list past capacity, then drain it
    wait_idle();
    set_view(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
    queue_request(REQ_DRAIN, 16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000);
    for (int i = 0; i < LIST_DEPTH + 2; i++) request_backlog.push_back(rand_request(1'b1));
    queue_request(REQ_INSERT, 16'h0bad, 1'b1, 16'h0000, 16'h0000, 16'h0000);
    queue_request(REQ_APPEND, 16'h0bee, 1'b0, 16'h7fff, 16'h8000, 16'h8000);
    queue_request(REQ_DRAIN, 16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000);

    random_phase(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));

    wait_idle();
    repeat (16) @(posedge clk);
    if (due_results.size() != 0) begin
      $error("%0d results never arrived", due_results.size());
      errors++;
    end
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
